@@ sv/arq_pkg.sv @@
`default_nettype none
package arq_pkg;

    localparam int MAX_TASKS = 16;
    localparam int NUM_CPUS  = 2;
    localparam int TASK_W    = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);
    localparam int CPU_W     = 1;
    localparam int AFF_W     = NUM_CPUS;

    typedef enum logic [2:0] {
        CMD_ENQUEUE = 3'd0,
        CMD_PICK    = 3'd1,
        CMD_YIELD   = 3'd2,
        CMD_REMOVE  = 3'd3,
        CMD_SET_AFF = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_IDLE   = 2'd1,
        ST_DUP    = 2'd2,
        ST_ABSENT = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic    load;
        logic    push;
        logic    set_aff;
        logic    idx_clr;
        logic    idx_inc;
        logic    take;
        logic    shift;
        logic    cnt_dec;
        logic    st_wr;
        status_t st_code;
    } ctl_t;

    // datapath -> controller
    typedef struct packed {
        cmd_t cmd;
        logic is_queued;
        logic full;
        logic scan_end;
        logic match;
        logic shift_more;
    } sts_t;

endpackage
`default_nettype wire

@@ sv/arq_datapath.sv @@
`default_nettype none
module arq_datapath
    import arq_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic [2:0]          command,
    input  wire logic [TASK_W-1:0]   task_id,
    input  wire logic [CPU_W-1:0]    cpu_id,
    input  wire logic [AFF_W-1:0]    affinity,
    input  wire ctl_t                ctl,
    output sts_t                     sts,
    output logic [1:0]               status,
    output logic [TASK_W-1:0]        picked_task
);

    logic [TASK_W-1:0] queue_reg [MAX_TASKS];
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [MAX_TASKS-1:0] in_queue_reg;
    logic [AFF_W-1:0]  aff_reg [MAX_TASKS];

    cmd_t              cmd_reg;
    logic [TASK_W-1:0] task_reg;
    logic [CPU_W-1:0]  cpu_reg;
    logic [AFF_W-1:0]  mask_reg;
    status_t           status_reg;
    logic [TASK_W-1:0] picked_reg;

    logic [TASK_W-1:0] idx;
    logic [TASK_W-1:0] idx_up;
    logic [TASK_W-1:0] head_task;
    logic [CNT_W-1:0]  idx_plus;

    assign idx       = idx_reg[TASK_W-1:0];
    assign idx_plus  = idx_reg + CNT_W'(1);
    assign idx_up    = idx_plus[TASK_W-1:0];
    assign head_task = queue_reg[idx];

    always_comb
    begin
        sts.cmd        = cmd_reg;
        sts.is_queued  = in_queue_reg[task_reg];
        sts.full       = (count_reg == CNT_W'(MAX_TASKS));
        sts.scan_end   = (idx_reg >= count_reg);
        sts.shift_more = (idx_plus < count_reg);
        if (cmd_reg == CMD_REMOVE)
            sts.match = (head_task == task_reg);
        else
            sts.match = aff_reg[head_task][cpu_reg];
    end

    assign status      = status_reg;
    assign picked_task = picked_reg;

    // latched command and results
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg  <= cmd_t'(command);
            task_reg <= task_id;
            cpu_reg  <= cpu_id;
            mask_reg <= affinity;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            status_reg <= ST_OK;
            picked_reg <= '0;
        end
        else
        begin
            if (ctl.st_wr)
                status_reg <= ctl.st_code;
            if (ctl.take && cmd_reg != CMD_REMOVE)
                picked_reg <= head_task;
        end
    end

    // queue slots: undefined until written
    always_ff @(posedge clk)
    begin
        if (ctl.push)
            queue_reg[count_reg[TASK_W-1:0]] <= task_reg;
        else if (ctl.shift)
            queue_reg[idx] <= queue_reg[idx_up];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            idx_reg      <= '0;
            in_queue_reg <= '0;
            for (int i = 0; i < MAX_TASKS; i++)
                aff_reg[i] <= '1;
        end
        else
        begin
            if (ctl.push)
                count_reg <= count_reg + CNT_W'(1);
            else if (ctl.cnt_dec)
                count_reg <= count_reg - CNT_W'(1);

            if (ctl.idx_clr)
                idx_reg <= '0;
            else if (ctl.idx_inc || ctl.shift)
                idx_reg <= idx_plus;

            if (ctl.push)
                in_queue_reg[task_reg] <= 1'b1;
            else if (ctl.take)
                in_queue_reg[head_task] <= 1'b0;

            if (ctl.set_aff)
                aff_reg[task_reg] <= mask_reg;
        end
    end

endmodule
`default_nettype wire

@@ sv/arq_controller.sv @@
`default_nettype none
module arq_controller
    import arq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    input  wire sts_t sts,
    output ctl_t      ctl,
    output logic      busy,
    output logic      done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                case (sts.cmd)
                    CMD_PICK, CMD_YIELD: state_next = S_SCAN;
                    CMD_REMOVE:
                    begin
                        if (sts.is_queued)
                            state_next = S_SCAN;
                        else
                            state_next = S_DONE;
                    end
                    default: state_next = S_DONE;
                endcase
            end
            S_SCAN:
            begin
                if (sts.scan_end)
                    state_next = S_DONE;
                else if (sts.match)
                    state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (!sts.shift_more)
                    state_next = S_DONE;
            end
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl         = '0;
        ctl.st_code = ST_OK;
        busy        = (state_reg != S_IDLE);
        done        = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                ctl.load = start;
            end
            S_DECODE:
            begin
                ctl.idx_clr = 1'b1;
                case (sts.cmd)
                    CMD_ENQUEUE:
                    begin
                        if (sts.is_queued || sts.full)
                        begin
                            ctl.st_wr   = 1'b1;
                            ctl.st_code = ST_DUP;
                        end
                        else
                            ctl.push = 1'b1;
                    end
                    CMD_YIELD:
                    begin
                        ctl.push = !sts.is_queued && !sts.full;
                    end
                    CMD_REMOVE:
                    begin
                        if (!sts.is_queued)
                        begin
                            ctl.st_wr   = 1'b1;
                            ctl.st_code = ST_ABSENT;
                        end
                    end
                    CMD_SET_AFF:
                    begin
                        ctl.set_aff = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SCAN:
            begin
                if (sts.scan_end)
                begin
                    // in_queue keeps a removed task always findable
                    ctl.st_wr   = 1'b1;
                    ctl.st_code = (sts.cmd == CMD_REMOVE) ? ST_ABSENT : ST_IDLE;
                end
                else if (sts.match)
                    ctl.take = 1'b1;
                else
                    ctl.idx_inc = 1'b1;
            end
            S_SHIFT:
            begin
                // close the gap one slot per cycle
                if (sts.shift_more)
                    ctl.shift = 1'b1;
                else
                    ctl.cnt_dec = 1'b1;
            end
            S_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

@@ sv/affinity_ready_queue_unit.sv @@
`default_nettype none
// Affinity ready queue: FIFO of task numbers with a per-task CPU mask.
// Command channel: command, task_id, cpu_id and affinity transfer at a rising
// edge with start high and busy low. busy stays high until the result is out.
// Result channel: status and picked_task are valid for exactly one cycle while
// done is high; the receiver takes them then and cannot hold them off.
// Sequence from the accepting edge to done:
//   enqueue, set affinity, unused codes, remove of an absent task: decode, then
//   done. pick / yield / remove: decode, then a scan from the head of the queue
//   (after the yield's enqueue) one slot per cycle to the first match, then the
//   shift that closes the gap one slot per cycle, then done; with no match the
//   scan walks the whole queue and goes straight to done.
// One command is in flight at a time; the next may start in the cycle after
// done. Reset (rst_n low) empties the queue and gives every task an all-CPU
// mask; queue slots themselves are not cleared.
module affinity_ready_queue_unit
    import arq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic [2:0]        command,
    input  wire logic [TASK_W-1:0] task_id,
    input  wire logic [CPU_W-1:0]  cpu_id,
    input  wire logic [AFF_W-1:0]  affinity,
    output logic                   done,
    output logic [1:0]             status,
    output logic [TASK_W-1:0]      picked_task
);

    ctl_t ctl;
    sts_t sts;

    arq_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    arq_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .command     (command),
        .task_id     (task_id),
        .cpu_id      (cpu_id),
        .affinity    (affinity),
        .ctl         (ctl),
        .sts         (sts),
        .status      (status),
        .picked_task (picked_task)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after command transfer");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("done longer than one cycle");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result without command in flight");

    a_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> picked_task == '0)
        else $error("picked task on failed command");

endmodule
`default_nettype wire

@@ tb/sv/ready_queue_checker.sv @@
`default_nettype none
module ready_queue_checker
    import arq_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              busy,
    input  wire logic [2:0]        command,
    input  wire logic [TASK_W-1:0] task_id,
    input  wire logic [CPU_W-1:0]  cpu_id,
    input  wire logic [AFF_W-1:0]  affinity,
    input  wire logic              done,
    input  wire logic [1:0]        status,
    input  wire logic [TASK_W-1:0] picked_task,
    output int                     fail_count,
    output int                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        status_t           status;
        logic [TASK_W-1:0] picked;
    } outcome_t;

    // shadow of the ready queue
    logic [TASK_W-1:0] order_q [MAX_TASKS];
    int                depth;
    logic [MAX_TASKS-1:0] queued;
    logic [AFF_W-1:0]  mask_tbl [MAX_TASKS];

    outcome_t          outcome_q [$];
    int                errors;

    function automatic status_t append_task(logic [TASK_W-1:0] tid);
        if (int'(tid) >= MAX_TASKS)
            return ST_ABSENT;
        if (queued[tid] || depth >= MAX_TASKS)
            return ST_DUP;
        order_q[depth] = tid;
        depth++;
        queued[tid] = 1'b1;
        return ST_OK;
    endfunction

    // take one slot out and close the gap, order kept
    function automatic void drop_slot(int pos);
        queued[order_q[pos]] = 1'b0;
        for (int i = pos; i + 1 < depth; i++)
            order_q[i] = order_q[i + 1];
        depth--;
    endfunction

    function automatic status_t pick_for(logic [CPU_W-1:0] cpu,
                                         output logic [TASK_W-1:0] picked);
        picked = '0;
        if (int'(cpu) >= NUM_CPUS)
            return ST_IDLE;
        for (int i = 0; i < depth; i++) begin
            if (mask_tbl[order_q[i]][cpu]) begin
                picked = order_q[i];
                drop_slot(i);
                return ST_OK;
            end
        end
        return ST_IDLE;
    endfunction

    function automatic status_t remove_task(logic [TASK_W-1:0] tid);
        if (int'(tid) >= MAX_TASKS || !queued[tid])
            return ST_ABSENT;
        for (int i = 0; i < depth; i++) begin
            if (order_q[i] == tid) begin
                drop_slot(i);
                return ST_OK;
            end
        end
        queued[tid] = 1'b0;
        return ST_ABSENT;
    endfunction

    function automatic outcome_t apply_command(logic [2:0] cmd, logic [TASK_W-1:0] tid,
                                               logic [CPU_W-1:0] cpu,
                                               logic [AFF_W-1:0] aff);
        outcome_t          res;
        logic [TASK_W-1:0] pk;
        res.status = ST_OK;
        res.picked = '0;
        pk = '0;
        case (cmd)
            CMD_ENQUEUE: res.status = append_task(tid);
            CMD_PICK: begin
                res.status = pick_for(cpu, pk);
                res.picked = pk;
            end
            // requeue is skipped silently when the task is already queued or the queue is full
            CMD_YIELD: begin
                void'(append_task(tid));
                res.status = pick_for(cpu, pk);
                res.picked = pk;
            end
            CMD_REMOVE: res.status = remove_task(tid);
            CMD_SET_AFF: begin
                if (int'(tid) < MAX_TASKS)
                    mask_tbl[tid] = aff;
                else
                    res.status = ST_ABSENT;
            end
            default: ;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin
        outcome_t oldest;
        if (!rst_n) begin
            depth = 0;
            queued = '0;
            for (int i = 0; i < MAX_TASKS; i++) begin
                mask_tbl[i] = '1;
                order_q[i] = '0;
            end
            outcome_q.delete();
            errors = 0;
            pending <= 0;
            fail_count <= 0;
        end
        else begin
            // result first, then any command that transfers at this edge
            if (done) begin
                if (outcome_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result with nothing outstanding: status %0d picked %0d",
                                 $realtime, status, picked_task);
                end
                else begin
                    oldest = outcome_q.pop_front();
                    if (status !== oldest.status || picked_task !== oldest.picked) begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch: expected status %0d picked %0d, got status %0d picked %0d",
                                     $realtime, oldest.status, oldest.picked, status,
                                     picked_task);
                    end
                end
            end
            if (start && !busy)
                outcome_q.push_back(apply_command(command, task_id, cpu_id, affinity));
            pending <= outcome_q.size();
            fail_count <= errors;
        end
    end

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
`default_nettype none
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import arq_pkg::*;

    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int         ITEMS_PER_PHASE = 267;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic [2:0]        command = '0;
    logic [TASK_W-1:0] task_id = '0;
    logic [CPU_W-1:0]  cpu_id = '0;
    logic [AFF_W-1:0]  affinity = '0;
    logic              busy;
    logic              done;
    logic [1:0]        status;
    logic [TASK_W-1:0] picked_task;
    int                fail_cnt;
    int                pending_cnt;
    int                gap_pct;

    always #4 clk = ~clk;

    affinity_ready_queue_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .task_id     (task_id),
        .cpu_id      (cpu_id),
        .affinity    (affinity),
        .done        (done),
        .status      (status),
        .picked_task (picked_task)
    );

    ready_queue_checker checker_inst (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .task_id     (task_id),
        .cpu_id      (cpu_id),
        .affinity    (affinity),
        .done        (done),
        .status      (status),
        .picked_task (picked_task),
        .fail_count  (fail_cnt),
        .pending     (pending_cnt)
    );

    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

    // start stays high after a transfer unless a gap follows
    task automatic sender_gap();
        if ($urandom_range(0, 99) < gap_pct) begin
            start <= 1'b0;
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(5, 40)) @(posedge clk);
            else
                repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic issue_cmd(logic [2:0] cmd, logic [TASK_W-1:0] tid,
                             logic [CPU_W-1:0] cpu, logic [AFF_W-1:0] aff);
        start <= 1'b1;
        command <= cmd;
        task_id <= tid;
        cpu_id <= cpu;
        affinity <= aff;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sender_gap();
    endtask

    initial begin
        int          enq_weight;
        int          pick_roll;
        int          guard;
        logic [2:0]  cmd;
        logic [AFF_W-1:0] aff;

        gap_pct = 8;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue, duplicates, masks that skip, gap closing
        issue_cmd(CMD_PICK, 4'd15, 1'b1, 2'd3);
        issue_cmd(CMD_REMOVE, 4'd15, 1'b0, 2'd0);
        issue_cmd(CMD_ENQUEUE, 4'd0, 1'b0, 2'd0);
        issue_cmd(CMD_ENQUEUE, 4'd15, 1'b1, 2'd3);
        issue_cmd(CMD_ENQUEUE, 4'd7, 1'b0, 2'd1);
        issue_cmd(CMD_ENQUEUE, 4'd15, 1'b0, 2'd2);
        issue_cmd(CMD_SET_AFF, 4'd0, 1'b0, 2'd2);
        issue_cmd(CMD_SET_AFF, 4'd15, 1'b1, 2'd0);
        issue_cmd(CMD_PICK, 4'd0, 1'b0, 2'd0);
        issue_cmd(CMD_PICK, 4'd15, 1'b0, 2'd3);
        issue_cmd(CMD_YIELD, 4'd15, 1'b1, 2'd0);
        issue_cmd(CMD_REMOVE, 4'd15, 1'b1, 2'd3);
        issue_cmd(CMD_REMOVE, 4'd15, 1'b0, 2'd0);
        issue_cmd(CMD_SET_AFF, 4'd15, 1'b0, 2'd3);
        issue_cmd(CMD_SET_AFF, 4'd0, 1'b1, 2'd1);
        issue_cmd(CMD_ENQUEUE, 4'd1, 1'b0, 2'd0);
        issue_cmd(CMD_ENQUEUE, 4'd2, 1'b0, 2'd0);
        issue_cmd(CMD_ENQUEUE, 4'd3, 1'b0, 2'd0);
        issue_cmd(CMD_REMOVE, 4'd2, 1'b0, 2'd0);
        issue_cmd(CMD_YIELD, 4'd9, 1'b1, 2'd2);
        issue_cmd(CMD_SPARE_LO, 4'd0, 1'b0, 2'd0);
        issue_cmd(CMD_SPARE_HI, 4'd15, 1'b1, 2'd3);
        issue_cmd(CMD_PICK, 4'd0, 1'b1, 2'd0);
        issue_cmd(CMD_PICK, 4'd0, 1'b0, 2'd0);

        // random: the enqueue share moves in blocks so the queue fills and drains
        enq_weight = 45;
        for (int phase = 0; phase < 3; phase++) begin
            gap_pct = (phase == 0) ? 8 : (phase == 1) ? 65 : 0;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (i % 20 == 0) begin
                    case ($urandom_range(0, 2))
                        0: enq_weight = 15;
                        1: enq_weight = 45;
                        default: enq_weight = 80;
                    endcase
                end
                pick_roll = $urandom_range(0, 99);
                if ($urandom_range(0, 99) < enq_weight)
                    cmd = CMD_ENQUEUE;
                else if (pick_roll < 30)
                    cmd = CMD_PICK;
                else if (pick_roll < 50)
                    cmd = CMD_YIELD;
                else if (pick_roll < 75)
                    cmd = CMD_REMOVE;
                else if (pick_roll < 93)
                    cmd = CMD_SET_AFF;
                else
                    cmd = 3'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
                // an all-zero mask strands a task, keep it uncommon
                if (cmd == CMD_SET_AFF && $urandom_range(0, 7) != 0)
                    aff = AFF_W'($urandom_range(1, 3));
                else
                    aff = AFF_W'($urandom_range(0, 3));
                issue_cmd(cmd, TASK_W'($urandom_range(0, MAX_TASKS - 1)),
                          CPU_W'($urandom_range(0, 1)), aff);
            end
        end
        start <= 1'b0;

        guard = 0;
        while (pending_cnt != 0 && guard < 2000) begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);

        if (fail_cnt == 0 && pending_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
